### src/ihv_pkg.sv
// Shared types, constants and character classification for the host string validator.
// No dependencies; used by ihv_scan and the top level.
package ihv_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned HOST_LEN_W   = 8;
  localparam int unsigned LABEL_LEN_W  = 7;
  localparam int unsigned TOTAL_W      = 9;
  localparam int unsigned SEG_DIG_W    = 3;
  localparam int unsigned SEG_VAL_W    = 10;
  localparam int unsigned DOT_W        = 3;
  localparam int unsigned LABEL_CNT_W  = 8;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [HOST_LEN_W-1:0]  HOST_LEN_RESET  = 8'd253;
  localparam logic [LABEL_LEN_W-1:0] LABEL_LEN_RESET = 7'd63;
  localparam logic [SEG_VAL_W-1:0]   OCTET_MAX       = 10'd255;
  localparam logic [DOT_W-1:0]       DOTS_NEEDED     = 3'd3;
  localparam logic [SEG_DIG_W-1:0]   SEG_DIGITS_MAX  = 3'd3;
  localparam logic [TOTAL_W-1:0]     TOTAL_SAT       = 9'd511;
  localparam logic [DOT_W-1:0]       DOT_SAT         = 3'd7;
  localparam logic [LABEL_CNT_W-1:0] LABEL_SAT       = 8'd255;

  localparam logic [CHAR_W-1:0] CH_HYPHEN     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;

  // Item kinds carried on the input tuser bit.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL = 1'b1;

  typedef struct packed {
    logic is_valid;
    logic looked_like_address;
  } verdict_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

### src/ihv_scan.sv
// Running string state of the validator: IPv4 and hostname checks side by side,
// updated once per accepted beat, plus the verdict for an end beat. Uses ihv_pkg.
module ihv_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              beat_acc,
  input  logic                              op_end,
  input  logic [ihv_pkg::CHAR_W-1:0]        char_code,
  input  logic [ihv_pkg::HOST_LEN_W-1:0]    max_host_length,
  input  logic [ihv_pkg::LABEL_LEN_W-1:0]   max_label_length,
  output ihv_pkg::verdict_t                 verdict
);
  import ihv_pkg::*;

  logic [TOTAL_W-1:0]     total_r,     total_nxt;
  logic                   only_dd_r,   only_dd_nxt;
  logic [SEG_DIG_W-1:0]   seg_dig_r,   seg_dig_nxt;
  logic [SEG_VAL_W-1:0]   seg_val_r,   seg_val_nxt;
  logic [DOT_W-1:0]       dots_r,      dots_nxt;
  logic                   addr_ok_r,   addr_ok_nxt;
  logic [LABEL_CNT_W-1:0] label_r,     label_nxt;
  logic                   name_ok_r,   name_ok_nxt;
  logic [CHAR_W-1:0]      prev_r,      prev_nxt;

  logic       c_digit, c_alnum, c_dot, c_hyphen, c_under;
  logic       seg_good, empty, label_fits, too_long;
  logic [SEG_VAL_W+3:0] seg_mult;

  assign c_digit  = is_digit(char_code);
  assign c_alnum  = is_alnum(char_code);
  assign c_dot    = (char_code == CH_DOT);
  assign c_hyphen = (char_code == CH_HYPHEN);
  assign c_under  = (char_code == CH_UNDERSCORE);

  assign seg_good   = (seg_dig_r != '0) && (seg_dig_r <= SEG_DIGITS_MAX) &&
                      (seg_val_r <= OCTET_MAX);
  assign empty      = (total_r == '0);
  assign label_fits = (label_r != '0) &&
                      (label_r <= {1'b0, max_label_length});
  assign too_long   = (total_r > {1'b0, max_host_length});

  // value * 10 + digit, as two shifted adds; only used below three digits.
  assign seg_mult = {1'b0, seg_val_r, 3'b000} + {3'b000, seg_val_r, 1'b0} +
                    {6'd0, char_code - CH_ZERO};

  always_comb begin
    verdict.looked_like_address = only_dd_r && !empty;
    if (empty) begin
      verdict.is_valid = 1'b0;
    end else if (only_dd_r) begin
      verdict.is_valid = addr_ok_r && (dots_r == DOTS_NEEDED) && seg_good && !too_long;
    end else begin
      verdict.is_valid = name_ok_r && (prev_r != CH_HYPHEN) && (prev_r != CH_DOT) &&
                         label_fits && !too_long;
    end
  end

  always_comb begin
    total_nxt   = total_r;
    only_dd_nxt = only_dd_r;
    seg_dig_nxt = seg_dig_r;
    seg_val_nxt = seg_val_r;
    dots_nxt    = dots_r;
    addr_ok_nxt = addr_ok_r;
    label_nxt   = label_r;
    name_ok_nxt = name_ok_r;
    prev_nxt    = prev_r;
    if (beat_acc && op_end) begin
      total_nxt   = '0;
      only_dd_nxt = 1'b1;
      seg_dig_nxt = '0;
      seg_val_nxt = '0;
      dots_nxt    = '0;
      addr_ok_nxt = 1'b1;
      label_nxt   = '0;
      name_ok_nxt = 1'b1;
      prev_nxt    = '0;
    end else if (beat_acc) begin
      if (total_r != TOTAL_SAT) begin
        total_nxt = total_r + 1'b1;
      end
      if (!c_digit && !c_dot) begin
        only_dd_nxt = 1'b0;
      end
      // Dotted-quad check.
      if (c_digit) begin
        if (seg_dig_r < SEG_DIGITS_MAX) begin
          seg_val_nxt = seg_mult[SEG_VAL_W-1:0];
        end
        if (seg_dig_r <= SEG_DIGITS_MAX) begin
          seg_dig_nxt = seg_dig_r + 1'b1;
        end
      end else if (c_dot) begin
        if (!seg_good) begin
          addr_ok_nxt = 1'b0;
        end
        if (dots_r != DOT_SAT) begin
          dots_nxt = dots_r + 1'b1;
        end
        seg_dig_nxt = '0;
        seg_val_nxt = '0;
      end
      // Hostname check.
      if (empty && !c_alnum) begin
        name_ok_nxt = 1'b0;
      end
      if (c_dot) begin
        if (!label_fits || (prev_r == CH_HYPHEN)) begin
          name_ok_nxt = 1'b0;
        end
        label_nxt = '0;
      end else begin
        if (!c_alnum && !c_hyphen && !c_under) begin
          name_ok_nxt = 1'b0;
        end
        if ((label_r == '0) && c_hyphen) begin
          name_ok_nxt = 1'b0;
        end
        if (label_r != LABEL_SAT) begin
          label_nxt = label_r + 1'b1;
        end
      end
      prev_nxt = char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      only_dd_r <= 1'b1;
      seg_dig_r <= '0;
      seg_val_r <= '0;
      dots_r    <= '0;
      addr_ok_r <= 1'b1;
      label_r   <= '0;
      name_ok_r <= 1'b1;
      prev_r    <= '0;
    end else begin
      total_r   <= total_nxt;
      only_dd_r <= only_dd_nxt;
      seg_dig_r <= seg_dig_nxt;
      seg_val_r <= seg_val_nxt;
      dots_r    <= dots_nxt;
      addr_ok_r <= addr_ok_nxt;
      label_r   <= label_nxt;
      name_ok_r <= name_ok_nxt;
      prev_r    <= prev_nxt;
    end
  end

endmodule

### src/ipv4_or_hostname_validator.sv
// Top level of the host string validator: stream handshake, configuration
// registers and result register around ihv_scan. Uses ihv_pkg.
//
// The block checks a host string fed one byte per input beat and, when an end
// beat arrives, returns one verdict beat saying whether the string is a valid
// dotted-quad IPv4 address or a valid hostname. Character beats produce no
// output. A string of only digits and dots is judged as an address (exactly
// three dots, 1 to 3 digits per segment, each segment at most 255); any other
// string is judged as a hostname (alphanumeric first character, last character
// neither hyphen nor dot, labels of 1 to max_label_length characters of
// alphanumerics, hyphen or underscore that do not start or end with a hyphen).
// Strings longer than max_host_length fail, and an end beat with no characters
// before it gives an invalid, non-address verdict. The running counters update in
// the cycle a beat is accepted, and the verdict lands in a single output register
// the next cycle, so a beat can be accepted every cycle as long as the output side
// keeps taking results. in_tready drops only while a verdict sits unconsumed in the
// output register. Configuration writes take effect at the next clock edge and
// should be made between strings.
module ipv4_or_hostname_validator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] char_code
  input  logic                              in_tuser,   // [0] operation (1 = end)
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [0] is_valid, [7:1] zero
  output logic                              out_tuser,  // [0] looked_like_address
  input  logic                              cfg_we,
  input  logic [ihv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ihv_pkg::HOST_LEN_W-1:0]    cfg_wdata
);
  import ihv_pkg::*;

  logic [HOST_LEN_W-1:0]  max_host_r;
  logic [LABEL_LEN_W-1:0] max_label_r;
  logic                   out_valid_r;
  verdict_t               result_r;
  verdict_t               verdict;
  logic                   in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ihv_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat_acc         (in_acc),
    .op_end           (in_tuser == OP_END),
    .char_code        (in_tdata),
    .max_host_length  (max_host_r),
    .max_label_length (max_label_r),
    .verdict          (verdict)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_host_r  <= HOST_LEN_RESET;
      max_label_r <= LABEL_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_HOST:  max_host_r  <= cfg_wdata;
        REG_MAX_LABEL: max_label_r <= cfg_wdata[LABEL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: loaded by an end beat, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (in_tuser == OP_END)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == OP_END)) begin
      result_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, result_r.is_valid};
  assign out_tuser  = result_r.looked_like_address;

endmodule

### src/ihv_checker.sv
// Port-level checker for the host string validator, bound to the top level.
// Depends only on the top level's ports.
module ihv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // A stalled verdict beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("verdict beat changed while stalled");

  // The input is never blocked while the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A character beat never creates a verdict.
  a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("verdict appeared after a character beat");

  // Two end beats in a row close an empty string: invalid and not an address.
  a_empty_string: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) ##1 (in_tvalid && in_tready && in_tuser)
      |=> out_tvalid && !out_tdata[0] && !out_tuser)
    else $error("empty string gave a wrong verdict");

endmodule

bind ipv4_or_hostname_validator ihv_checker u_ihv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
